// ----- rtl/core/pce_pkg.sv -----
`default_nettype none

package pce_pkg;

   localparam int MAX_WIDTH_DEFAULT = 64;
   localparam int CRC_BITS          = 64;
   localparam int WIDTH_BITS        = 7;
   localparam int INDEX_BITS        = 3;
   localparam int BYTE_BITS         = 8;
   localparam int STEPS_PER_CYCLE   = 8;

   localparam logic [WIDTH_BITS-1:0] RESET_CRC_WIDTH   = 7'd32;
   localparam logic [CRC_BITS-1:0]   RESET_POLYNOMIAL  = 64'h0000_0000_04C1_1DB7;
   localparam logic [CRC_BITS-1:0]   RESET_INIT_VALUE  = 64'h0000_0000_FFFF_FFFF;
   localparam logic                  RESET_INIT_IS_AUG = 1'b0;
   localparam logic                  RESET_REFLECT_IN  = 1'b1;
   localparam logic                  RESET_REFLECT_OUT = 1'b1;
   localparam logic [CRC_BITS-1:0]   RESET_XOR_OUT     = 64'h0000_0000_FFFF_FFFF;

   typedef enum logic [INDEX_BITS-1:0] {
      REG_CRC_WIDTH         = 3'd0,
      REG_POLYNOMIAL        = 3'd1,
      REG_INIT_VALUE        = 3'd2,
      REG_INIT_IS_AUGMENTED = 3'd3,
      REG_REFLECT_IN        = 3'd4,
      REG_REFLECT_OUT       = 3'd5,
      REG_XOR_OUT           = 3'd6
   } csr_index_type;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

endpackage

`default_nettype wire

// ----- rtl/core/parameterized_crc_engine.sv -----
// Data byte: one transaction per cycle while in ST_RUN, no result.
// End of message: CRC in the result register in the cycle after acceptance; if crc_width or
// polynomial was written inside the message, after an ST_FIN pass (8 register steps a cycle).
// Start-value pass after reset and after every csr write: ST_LOAD, ST_REV (skipped with
// augmented init), then ST_FWD, req_ready low meanwhile. Reset is synchronous.
`default_nettype none

module parameterized_crc_engine #(
   parameter int MAX_WIDTH = pce_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_kind,
   input  wire logic [pce_pkg::BYTE_BITS-1:0]        req_data_byte,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [pce_pkg::CRC_BITS-1:0]              rsp_crc_value,
   input  wire logic                                 csr_write_enable,
   input  wire logic [pce_pkg::INDEX_BITS-1:0]       csr_index,
   input  wire logic [pce_pkg::CRC_BITS-1:0]         csr_write_data
);

   localparam int W  = MAX_WIDTH;
   localparam int IW = (W > 1) ? $clog2(W) : 1;
   localparam int NB = pce_pkg::WIDTH_BITS;
   localparam int SP = pce_pkg::STEPS_PER_CYCLE;
   localparam logic [NB-1:0] W_N = NB'(W);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_REV,
      ST_FWD,
      ST_RUN,
      ST_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [NB-1:0]     cnt_ff, cnt_in;
   logic [W-1:0]      work_ff, work_in;
   logic [W-1:0]      start_aug_ff, start_aug_in;
   logic [W-1:0]      start_dir_ff, start_dir_in;
   logic [W-1:0]      aug_reg_ff, aug_reg_in;
   logic [W-1:0]      dir_reg_ff, dir_reg_in;
   logic              dir_ok_ff, dir_ok_in;
   logic              fresh_ff, fresh_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]      rsp_crc_ff, rsp_crc_in;

   logic [NB-1:0]     cw_ff, cw_in;
   logic [W-1:0]      poly_ff, poly_in;
   logic [W-1:0]      init_ff, init_in;
   logic              init_aug_ff, init_aug_in;
   logic              rin_ff, rin_in;
   logic              rout_ff, rout_in;
   logic [W-1:0]      xout_ff, xout_in;

   logic [NB-1:0]     n_eff;
   logic [W-1:0]      mask;
   logic [W-1:0]      pmask;
   logic [IW-1:0]     top_idx;
   logic [W-1:0]      step_val;
   logic              step_done;
   logic [pce_pkg::BYTE_BITS-1:0] byte_bits;
   logic [W-1:0]      aug_base, dir_base, aug_next, dir_next;
   logic              req_accept;

   function automatic logic [W-1:0] fwd_step(input logic [W-1:0] r, input logic b,
                                             input logic [IW-1:0] ti, input logic [W-1:0] m,
                                             input logic [W-1:0] pm);
      logic         top;
      logic [W-1:0] v;
      top = r[ti];
      v   = ((r << 1) | W'(b)) & m;
      if (top) v = v ^ pm;
      return v;
   endfunction

   function automatic logic [W-1:0] dir_step(input logic [W-1:0] r, input logic b,
                                             input logic [IW-1:0] ti, input logic [W-1:0] m,
                                             input logic [W-1:0] pm);
      logic         top;
      logic [W-1:0] v;
      top = r[ti] ^ b;
      v   = (r << 1) & m;
      if (top) v = v ^ pm;
      return v;
   endfunction

   function automatic logic [W-1:0] rev_step(input logic [W-1:0] r, input logic [IW-1:0] ti,
                                             input logic [W-1:0] pm);
      logic         low;
      logic [W-1:0] v;
      low = r[0];
      v   = r;
      if (low) v = v ^ pm;
      v = v >> 1;
      if (low) v[ti] = 1'b1;
      return v;
   endfunction

   function automatic logic [W-1:0] finalize(input logic [W-1:0] d, input logic [NB-1:0] n,
                                             input logic ro, input logic [W-1:0] xo,
                                             input logic [W-1:0] m);
      logic [W-1:0] rv;
      logic [W-1:0] r;
      for (int j = 0; j < W; j++) rv[j] = d[W-1-j];
      r = ro ? (rv >> (W_N - n)) : d;
      return (r ^ xo) & m;
   endfunction

   always_comb begin
      if (cw_ff == '0) n_eff = NB'(1);
      else if (cw_ff > W_N) n_eff = W_N;
      else n_eff = cw_ff;
   end

   assign mask    = {W{1'b1}} >> (W_N - n_eff);
   assign pmask   = poly_ff & mask;
   assign top_idx = IW'(n_eff - NB'(1));

   always_comb begin
      step_val = work_ff;
      for (int i = 0; i < SP; i++) begin
         if (({1'b0, cnt_ff} + (NB+1)'(i)) < {1'b0, n_eff}) begin
            if (state_ff == ST_REV) step_val = rev_step(step_val, top_idx, pmask);
            else step_val = fwd_step(step_val, 1'b0, top_idx, mask, pmask);
         end
      end
   end

   assign step_done = ({1'b0, cnt_ff} + (NB+1)'(SP)) >= {1'b0, n_eff};

   always_comb begin
      for (int i = 0; i < pce_pkg::BYTE_BITS; i++) begin
         byte_bits[i] = rin_ff ? req_data_byte[pce_pkg::BYTE_BITS-1-i] : req_data_byte[i];
      end
   end

   assign aug_base = fresh_ff ? start_aug_ff : (aug_reg_ff & mask);
   assign dir_base = fresh_ff ? start_dir_ff : (dir_reg_ff & mask);

   always_comb begin
      aug_next = aug_base;
      dir_next = dir_base;
      for (int i = 0; i < pce_pkg::BYTE_BITS; i++) begin
         aug_next = fwd_step(aug_next, byte_bits[pce_pkg::BYTE_BITS-1-i], top_idx, mask,
                             pmask);
         dir_next = dir_step(dir_next, byte_bits[pce_pkg::BYTE_BITS-1-i], top_idx, mask,
                             pmask);
      end
   end

   assign req_ready  = (state_ff == ST_RUN) &&
                       ((req_kind == pce_pkg::KIND_DATA) || !rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      work_in      = work_ff;
      start_aug_in = start_aug_ff;
      start_dir_in = start_dir_ff;
      aug_reg_in   = aug_reg_ff;
      dir_reg_in   = dir_reg_ff;
      dir_ok_in    = dir_ok_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_crc_in   = rsp_crc_ff;
      cw_in        = cw_ff;
      poly_in      = poly_ff;
      init_in      = init_ff;
      init_aug_in  = init_aug_ff;
      rin_in       = rin_ff;
      rout_in      = rout_ff;
      xout_in      = xout_ff;

      unique case (state_ff)
         ST_LOAD: begin
            work_in      = init_ff & mask;
            start_aug_in = init_ff & mask;
            cnt_in       = '0;
            state_in     = init_aug_ff ? ST_FWD : ST_REV;
         end
         ST_REV: begin
            work_in = step_val;
            cnt_in  = cnt_ff + NB'(SP);
            if (step_done) begin
               start_aug_in = step_val;
               cnt_in       = '0;
               state_in     = ST_FWD;
            end
         end
         ST_FWD: begin
            work_in = step_val;
            cnt_in  = cnt_ff + NB'(SP);
            if (step_done) begin
               start_dir_in = step_val;
               state_in     = ST_RUN;
            end
         end
         ST_FIN: begin
            work_in = step_val;
            cnt_in  = cnt_ff + NB'(SP);
            if (step_done) begin
               rsp_valid_in = 1'b1;
               rsp_crc_in   = finalize(step_val, n_eff, rout_ff, xout_ff, mask);
               fresh_in     = 1'b1;
               state_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            if (req_accept) begin
               if (req_kind == pce_pkg::KIND_DATA) begin
                  aug_reg_in = aug_next;
                  dir_reg_in = dir_next;
                  dir_ok_in  = fresh_ff || dir_ok_ff;
                  fresh_in   = 1'b0;
               end else if (fresh_ff || dir_ok_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_crc_in   = finalize(dir_base, n_eff, rout_ff, xout_ff, mask);
                  fresh_in     = 1'b1;
               end else begin
                  // register width or polynomial changed inside the message
                  work_in  = aug_reg_ff & mask;
                  cnt_in   = '0;
                  state_in = ST_FIN;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase

      if (csr_write_enable) begin
         state_in = ST_LOAD;
         unique case (csr_index)
            pce_pkg::REG_CRC_WIDTH: begin
               cw_in = csr_write_data[NB-1:0];
               if (!fresh_ff) dir_ok_in = 1'b0;
            end
            pce_pkg::REG_POLYNOMIAL: begin
               poly_in = csr_write_data[W-1:0];
               if (!fresh_ff) dir_ok_in = 1'b0;
            end
            pce_pkg::REG_INIT_VALUE:        init_in     = csr_write_data[W-1:0];
            pce_pkg::REG_INIT_IS_AUGMENTED: init_aug_in = csr_write_data[0];
            pce_pkg::REG_REFLECT_IN:        rin_in      = csr_write_data[0];
            pce_pkg::REG_REFLECT_OUT:       rout_in     = csr_write_data[0];
            pce_pkg::REG_XOR_OUT:           xout_in     = csr_write_data[W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         dir_ok_ff    <= 1'b0;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         cw_ff        <= pce_pkg::RESET_CRC_WIDTH;
         poly_ff      <= pce_pkg::RESET_POLYNOMIAL[W-1:0];
         init_ff      <= pce_pkg::RESET_INIT_VALUE[W-1:0];
         init_aug_ff  <= pce_pkg::RESET_INIT_IS_AUG;
         rin_ff       <= pce_pkg::RESET_REFLECT_IN;
         rout_ff      <= pce_pkg::RESET_REFLECT_OUT;
         xout_ff      <= pce_pkg::RESET_XOR_OUT[W-1:0];
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dir_ok_ff    <= dir_ok_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         cw_ff        <= cw_in;
         poly_ff      <= poly_in;
         init_ff      <= init_in;
         init_aug_ff  <= init_aug_in;
         rin_ff       <= rin_in;
         rout_ff      <= rout_in;
         xout_ff      <= xout_in;
      end
      work_ff      <= work_in;
      start_aug_ff <= start_aug_in;
      start_dir_ff <= start_dir_in;
      aug_reg_ff   <= aug_reg_in;
      dir_reg_ff   <= dir_reg_in;
      rsp_crc_ff   <= rsp_crc_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = pce_pkg::CRC_BITS'(rsp_crc_ff);

endmodule

`default_nettype wire
